### hdl/mlm_pkg.sv
`timescale 1ns / 1ps
package mlm_pkg;

    localparam int MUTEX_SLOTS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int NEMIT_W         = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        OP_LOCK   = 3'd0,
        OP_UNLOCK = 3'd1,
        OP_CANCEL = 3'd2,
        OP_EXIT   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        CODE_OK    = 2'd0,
        CODE_WRONG = 2'd1,
        CODE_AGAIN = 2'd2,
        CODE_FULL  = 2'd3
    } t_code;

    // Engine to response stage.
    typedef struct packed {
        logic        emit;
        logic        flush;
        logic [31:0] reply_to;
        t_code       reply_code;
    } t_rsp_ctl;

    // Response stage to engine.
    typedef struct packed {
        logic emit_ok;
        logic flush_ok;
    } t_rsp_sts;

endpackage

### hdl/mlm_if.sv
`timescale 1ns / 1ps
interface mlm_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] process_id;
    logic signed [31:0] mutex_id;
    logic               notify_caller;

    modport source (output valid, output op, output process_id, output mutex_id,
                    output notify_caller, input ready);
    modport sink   (input valid, input op, input process_id, input mutex_id,
                    input notify_caller, output ready);
endinterface

interface mlm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] reply_to;
    logic [1:0]         reply_code;
    logic               last;

    modport source (output valid, output reply_to, output reply_code, output last,
                    input ready);
    modport sink   (input valid, input reply_to, input reply_code, input last,
                    output ready);
endinterface

### hdl/mlm_ram.sv
`timescale 1ns / 1ps
module mlm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mlm_rsp_stage.sv
`timescale 1ns / 1ps
module mlm_rsp_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mlm_pkg::t_rsp_ctl   i_ctl,
    output mlm_pkg::t_rsp_sts   o_sts,
    mlm_rsp_if.source           o_rsp
);

    // One reply is held back until the next one or the end of the request
    // shows whether it is the final one.
    logic                r_pend_v;
    logic [31:0]         r_pend_to;
    mlm_pkg::t_code      r_pend_code;
    logic                r_ov;
    logic [31:0]         r_o_to;
    mlm_pkg::t_code      r_o_code;
    logic                r_o_last;
    logic                w_ofree;
    logic                w_take;
    logic                w_fl;

    assign w_ofree        = !r_ov || o_rsp.ready;
    assign o_sts.emit_ok  = !r_pend_v || w_ofree;
    assign o_sts.flush_ok = !r_pend_v || w_ofree;
    assign w_take         = i_ctl.emit && o_sts.emit_ok;
    assign w_fl           = !w_take && i_ctl.flush && r_pend_v && w_ofree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            if (w_take) begin
                if (r_pend_v) begin
                    r_ov <= 1'b1;
                end
                r_pend_v <= 1'b1;
            end else if (w_fl) begin
                r_ov     <= 1'b1;
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pend_to   <= i_ctl.reply_to;
            r_pend_code <= i_ctl.reply_code;
            if (r_pend_v) begin
                r_o_to   <= r_pend_to;
                r_o_code <= r_pend_code;
                r_o_last <= 1'b0;
            end
        end else if (w_fl) begin
            r_o_to   <= r_pend_to;
            r_o_code <= r_pend_code;
            r_o_last <= 1'b1;
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.reply_to   = r_o_to;
    assign o_rsp.reply_code = r_o_code;
    assign o_rsp.last       = r_o_last;

endmodule

### hdl/mlm_engine.sv
`timescale 1ns / 1ps
module mlm_engine #(
    parameter int MUTEX_SLOTS = mlm_pkg::MUTEX_SLOTS_DEF,
    parameter int QUEUE_DEPTH = mlm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mlm_req_if.sink           i_req,
    output mlm_pkg::t_rsp_ctl o_ctl,
    input  mlm_pkg::t_rsp_sts i_sts
);

    localparam int SW     = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1;
    localparam int UW     = $clog2(MUTEX_SLOTS + 1);
    localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int WDEPTH = MUTEX_SLOTS * QUEUE_DEPTH;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int SLOT_W = 64 + QW + CW;
    localparam int NW     = mlm_pkg::NEMIT_W;

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_FIND_RD  = 18'h00002,
        S_FIND_CHK = 18'h00004,
        S_DROP_RD  = 18'h00008,
        S_DROP_CHK = 18'h00010,
        S_Q_RD     = 18'h00020,
        S_Q_CHK    = 18'h00040,
        S_EXIT_RD  = 18'h00080,
        S_EXIT_CHK = 18'h00100,
        S_REL      = 18'h00200,
        S_CPS_RD   = 18'h00400,
        S_CPS_WR   = 18'h00800,
        S_CPR_RD   = 18'h01000,
        S_CPR_WR   = 18'h02000,
        S_HAND_RD  = 18'h04000,
        S_HAND_WR  = 18'h08000,
        S_REL_RET  = 18'h10000,
        S_DONE     = 18'h20000
    } t_state;

    function automatic logic [QW-1:0] qwrap(input logic [QW:0] a);
        qwrap = (a >= (QW+1)'(QUEUE_DEPTH)) ? QW'(a - (QW+1)'(QUEUE_DEPTH)) : a[QW-1:0];
    endfunction

    function automatic logic [WAW-1:0] waddr(input logic [SW-1:0] s,
                                             input logic [QW-1:0] idx);
        waddr = WAW'(WAW'(s) * WAW'(QUEUE_DEPTH) + WAW'(idx));
    endfunction

    function automatic logic [SLOT_W-1:0] mkslot(input logic [31:0] mid,
                                                 input logic [31:0] holder,
                                                 input logic [QW-1:0] head,
                                                 input logic [CW-1:0] cnt);
        mkslot = {mid, holder, head, cnt};
    endfunction

    t_state            r_state, n_state;
    logic [2:0]        r_op, n_op;
    logic [31:0]       r_pid, n_pid;
    logic [31:0]       r_mid, n_mid;
    logic              r_notify, n_notify;
    logic [UW-1:0]     r_used, n_used;
    logic [UW-1:0]     r_s, n_s;
    logic [CW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_kept, n_kept;
    logic              r_hit, n_hit;
    logic [31:0]       r_mutex, n_mutex;
    logic [31:0]       r_holder, n_holder;
    logic [QW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [NW-1:0]     r_nemit, n_nemit;

    logic              w_s_we;
    logic [SW-1:0]     w_s_waddr, w_s_raddr;
    logic [SLOT_W-1:0] w_s_wdata, w_s_rdata;
    logic              w_w_we;
    logic [WAW-1:0]    w_w_waddr, w_w_raddr;
    logic [31:0]       w_w_wdata, w_w_rdata;

    logic [31:0]       w_rd_mutex, w_rd_holder;
    logic [QW-1:0]     w_rd_head;
    logic [CW-1:0]     w_rd_cnt;
    logic [UW-1:0]     w_last;
    logic              w_emit_req, w_drop, w_hold;
    logic [31:0]       w_e_to;
    mlm_pkg::t_code    w_e_code;
    logic              w_flush;

    assign w_rd_mutex  = w_s_rdata[SLOT_W-1 -: 32];
    assign w_rd_holder = w_s_rdata[SLOT_W-33 -: 32];
    assign w_rd_head   = w_s_rdata[CW +: QW];
    assign w_rd_cnt    = w_s_rdata[0 +: CW];
    assign w_last      = r_used - UW'(1);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_pid      = r_pid;
        n_mid      = r_mid;
        n_notify   = r_notify;
        n_used     = r_used;
        n_s        = r_s;
        n_k        = r_k;
        n_kept     = r_kept;
        n_hit      = r_hit;
        n_mutex    = r_mutex;
        n_holder   = r_holder;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_nemit    = r_nemit;
        w_s_we     = 1'b0;
        w_s_waddr  = r_s[SW-1:0];
        w_s_wdata  = mkslot(r_mutex, r_holder, r_head, r_cnt);
        w_s_raddr  = r_s[SW-1:0];
        w_w_we     = 1'b0;
        w_w_waddr  = waddr(r_s[SW-1:0], r_k[QW-1:0]);
        w_w_wdata  = w_w_rdata;
        w_w_raddr  = waddr(r_s[SW-1:0], r_k[QW-1:0]);
        w_emit_req = 1'b0;
        w_e_to     = r_pid;
        w_e_code   = mlm_pkg::CODE_OK;
        w_flush    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op     = i_req.op;
                    n_pid    = i_req.process_id;
                    n_mid    = i_req.mutex_id;
                    n_notify = i_req.notify_caller;
                    n_s      = '0;
                    n_hit    = 1'b0;
                    case (i_req.op)
                        mlm_pkg::OP_LOCK, mlm_pkg::OP_UNLOCK: n_state = S_FIND_RD;
                        mlm_pkg::OP_CANCEL, mlm_pkg::OP_EXIT: n_state = S_DROP_RD;
                        mlm_pkg::OP_CLEAR: begin
                            n_used  = '0;
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_FIND_RD: begin
                if (r_s >= r_used) begin
                    n_state = S_DONE;
                    if (r_op == mlm_pkg::OP_LOCK) begin
                        w_emit_req = 1'b1;
                        if (r_used >= UW'(MUTEX_SLOTS)) begin
                            w_e_code = mlm_pkg::CODE_FULL;
                        end else begin
                            w_s_we    = 1'b1;
                            w_s_waddr = r_used[SW-1:0];
                            w_s_wdata = mkslot(r_mid, r_pid, '0, '0);
                            n_used    = r_used + UW'(1);
                        end
                    end else begin
                        w_emit_req = r_notify;
                        w_e_code   = mlm_pkg::CODE_WRONG;
                    end
                end else begin
                    n_state = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                n_mutex  = w_rd_mutex;
                n_holder = w_rd_holder;
                n_head   = w_rd_head;
                n_cnt    = w_rd_cnt;
                if (w_rd_mutex == r_mid) begin
                    if (r_op == mlm_pkg::OP_LOCK) begin
                        n_state = S_DONE;
                        if (w_rd_cnt >= CW'(QUEUE_DEPTH)) begin
                            w_emit_req = 1'b1;
                            w_e_code   = mlm_pkg::CODE_FULL;
                        end else begin
                            w_w_we    = 1'b1;
                            w_w_waddr = waddr(r_s[SW-1:0],
                                              qwrap((QW+1)'(w_rd_head) + (QW+1)'(w_rd_cnt)));
                            w_w_wdata = r_pid;
                            w_s_we    = 1'b1;
                            w_s_wdata = mkslot(w_rd_mutex, w_rd_holder, w_rd_head,
                                               w_rd_cnt + CW'(1));
                        end
                    end else if (w_rd_holder == r_pid) begin
                        n_state = S_REL;
                    end else begin
                        w_emit_req = r_notify;
                        w_e_code   = mlm_pkg::CODE_WRONG;
                        n_state    = S_DONE;
                    end
                end else begin
                    n_s     = r_s + UW'(1);
                    n_state = S_FIND_RD;
                end
            end
            S_DROP_RD: begin
                if (r_s >= r_used) begin
                    if (r_op == mlm_pkg::OP_CANCEL) begin
                        w_emit_req = r_hit;
                        w_e_code   = mlm_pkg::CODE_AGAIN;
                        n_state    = S_DONE;
                    end else begin
                        n_s     = '0;
                        n_state = S_EXIT_RD;
                    end
                end else begin
                    n_state = S_DROP_CHK;
                end
            end
            S_DROP_CHK: begin
                n_mutex  = w_rd_mutex;
                n_holder = w_rd_holder;
                n_head   = w_rd_head;
                n_cnt    = w_rd_cnt;
                n_k      = '0;
                n_kept   = '0;
                n_state  = S_Q_RD;
            end
            S_Q_RD: begin
                if (r_k >= r_cnt) begin
                    w_s_we    = 1'b1;
                    w_s_wdata = mkslot(r_mutex, r_holder, r_head, r_kept);
                    n_s       = r_s + UW'(1);
                    n_state   = S_DROP_RD;
                end else begin
                    w_w_raddr = waddr(r_s[SW-1:0],
                                      qwrap((QW+1)'(r_head) + (QW+1)'(r_k[QW-1:0])));
                    n_state   = S_Q_CHK;
                end
            end
            S_Q_CHK: begin
                // Surviving waiters slide toward the head; writes trail reads.
                if (w_w_rdata == r_pid) begin
                    n_hit = 1'b1;
                end else begin
                    w_w_we    = 1'b1;
                    w_w_waddr = waddr(r_s[SW-1:0],
                                      qwrap((QW+1)'(r_head) + (QW+1)'(r_kept[QW-1:0])));
                    n_kept    = r_kept + CW'(1);
                end
                n_k     = r_k + CW'(1);
                n_state = S_Q_RD;
            end
            S_EXIT_RD: begin
                n_state = (r_s >= r_used) ? S_DONE : S_EXIT_CHK;
            end
            S_EXIT_CHK: begin
                n_mutex  = w_rd_mutex;
                n_holder = w_rd_holder;
                n_head   = w_rd_head;
                n_cnt    = w_rd_cnt;
                if (w_rd_holder == r_pid) begin
                    n_state = S_REL;
                end else begin
                    n_s     = r_s + UW'(1);
                    n_state = S_EXIT_RD;
                end
            end
            S_REL: begin
                if (r_cnt == '0) begin
                    if (r_s != w_last) begin
                        n_state = S_CPS_RD;
                    end else begin
                        n_used  = w_last;
                        n_state = S_REL_RET;
                    end
                end else begin
                    n_state = S_HAND_RD;
                end
            end
            S_CPS_RD: begin
                w_s_raddr = w_last[SW-1:0];
                n_state   = S_CPS_WR;
            end
            S_CPS_WR: begin
                w_s_we    = 1'b1;
                w_s_wdata = w_s_rdata;
                n_k       = '0;
                n_state   = S_CPR_RD;
            end
            S_CPR_RD: begin
                if (r_k == CW'(QUEUE_DEPTH)) begin
                    n_used  = w_last;
                    n_state = S_REL_RET;
                end else begin
                    w_w_raddr = waddr(w_last[SW-1:0], r_k[QW-1:0]);
                    n_state   = S_CPR_WR;
                end
            end
            S_CPR_WR: begin
                w_w_we  = 1'b1;
                n_k     = r_k + CW'(1);
                n_state = S_CPR_RD;
            end
            S_HAND_RD: begin
                w_w_raddr = waddr(r_s[SW-1:0], r_head);
                n_state   = S_HAND_WR;
            end
            S_HAND_WR: begin
                // Keep reading the head entry so a stalled reply sees the same waiter.
                w_w_raddr  = waddr(r_s[SW-1:0], r_head);
                w_s_we     = 1'b1;
                w_s_wdata  = mkslot(r_mutex, w_w_rdata, qwrap((QW+1)'(r_head) + (QW+1)'(1)),
                                    r_cnt - CW'(1));
                w_emit_req = 1'b1;
                w_e_to     = w_w_rdata;
                n_state    = S_REL_RET;
            end
            S_REL_RET: begin
                if (r_op == mlm_pkg::OP_UNLOCK) begin
                    w_emit_req = r_notify;
                    n_state    = S_DONE;
                end else begin
                    // The slot now holds other contents; look at it again.
                    n_state = S_EXIT_RD;
                end
            end
            S_DONE: begin
                w_flush = 1'b1;
                if (i_sts.flush_ok) begin
                    n_nemit = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_emit_req && !w_drop) begin
            n_nemit = r_nemit + NW'(1);
        end
    end

    assign w_drop = (r_nemit >= NW'(mlm_pkg::MAX_RESULTS));
    assign w_hold = w_emit_req && !w_drop && !i_sts.emit_ok;

    assign o_ctl.emit       = w_emit_req && !w_drop;
    assign o_ctl.flush      = w_flush;
    assign o_ctl.reply_to   = w_e_to;
    assign o_ctl.reply_code = w_e_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_nemit <= '0;
        end else if (!w_hold) begin
            r_state <= n_state;
            r_used  <= n_used;
            r_nemit <= n_nemit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_hold) begin
            r_op     <= n_op;
            r_pid    <= n_pid;
            r_mid    <= n_mid;
            r_notify <= n_notify;
            r_s      <= n_s;
            r_k      <= n_k;
            r_kept   <= n_kept;
            r_hit    <= n_hit;
            r_mutex  <= n_mutex;
            r_holder <= n_holder;
            r_head   <= n_head;
            r_cnt    <= n_cnt;
        end
    end

    mlm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MUTEX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we && !w_hold),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rdata)
    );

    mlm_ram #(
        .WIDTH (32),
        .DEPTH (WDEPTH)
    ) u_waiter_ram (
        .i_clk   (i_clk),
        .i_we    (w_w_we && !w_hold),
        .i_waddr (w_w_waddr),
        .i_wdata (w_w_wdata),
        .i_raddr (w_w_raddr),
        .o_rdata (w_w_rdata)
    );

endmodule

### hdl/mutex_lock_manager_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                   Handshake
// i_req     in   op, process_id, mutex_id, notify_caller   valid / ready
// o_rsp     out  reply_to, reply_code, last                valid / ready
//
// One request at a time. Lock and unlock scan the table slot by slot, reading
// each slot from the slot memory, then comparing it. Cancel and exit read each
// slot, step through its queued waiters with a read and a check for each, then
// write the slot back, and exit then rescans the table slot by slot; a release
// that compacts the table copies the last slot, then its queue row entry by entry.
// Reset clears only the control state; no clearing pass is needed.
// A stalled reply output holds the engine once one reply is already held back.
module mutex_lock_manager_top #(
    parameter int MUTEX_SLOTS = mlm_pkg::MUTEX_SLOTS_DEF,
    parameter int QUEUE_DEPTH = mlm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlm_req_if.sink   i_req,
    mlm_rsp_if.source o_rsp
);

    mlm_pkg::t_rsp_ctl w_ctl;
    mlm_pkg::t_rsp_sts w_sts;

    mlm_engine #(
        .MUTEX_SLOTS (MUTEX_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_ctl   (w_ctl),
        .i_sts   (w_sts)
    );

    mlm_rsp_stage u_rsp_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp)
    );

    a_no_emit_on_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.emit && w_ctl.flush))
        else $error("reply issued while closing a request");

    a_ready_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.flush && w_sts.flush_ok |=> i_req.ready)
        else $error("engine not ready after closing a request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("second request taken while one is in progress");

endmodule
